FILE: rtl/core/vector_cosine_similarity_unit_assert.svh
// Assertion macros shared by the vector cosine similarity checker.
`ifndef VECTOR_COSINE_SIMILARITY_UNIT_ASSERT_SVH
`define VECTOR_COSINE_SIMILARITY_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define VCSU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define VCSU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/vcs_pkg.sv
// Package with the shared types, constants and tables of the cosine similarity unit.
`timescale 1ns / 1ps
`default_nettype none
package vcs_pkg;

	localparam logic REG_MODE      = 1'b0;
	localparam logic REG_EXP_SCALE = 1'b1;

	localparam logic [1:0] MODE_COS = 2'd0;
	localparam logic [1:0] MODE_ANG = 2'd1;
	localparam logic [1:0] MODE_EXP = 2'd2;

	localparam logic [15:0] EXP_SCALE_RST = 16'd256;
	localparam logic [30:0] ONE30 = 31'h4000_0000;
	localparam logic [61:0] ONE60 = 62'h1000_0000_0000_0000;
	localparam logic [62:0] SQ_BIT_INIT = 63'h4000_0000_0000_0000;
	localparam logic [4:0] CORDIC_STEPS = 5'd24;
	localparam logic [24:0] QUARTER24 = 25'h100_0000;
	localparam logic [3:0] EXP_J_END = 4'd11;
	localparam logic [17:0] SIM_ONE = 18'd65536;

	localparam logic [23:0] ATAN_TAB [24] = '{
		24'd8388608, 24'd4952084, 24'd2616545, 24'd1328199, 24'd666677, 24'd333664,
		24'd166872, 24'd83441, 24'd41721, 24'd20861, 24'd10430, 24'd5215,
		24'd2608, 24'd1304, 24'd652, 24'd326, 24'd163, 24'd81,
		24'd41, 24'd20, 24'd10, 24'd5, 24'd3, 24'd1
	};

	// exp(-1), then exp(-2^-j) for j = 1 .. 10, all Q30.
	localparam logic [30:0] EXP_TAB [11] = '{
		31'd395007542, 31'd651257337, 31'd836230973, 31'd947573834, 31'd1008687096,
		31'd1040706261, 31'd1057095000, 31'd1065385899, 31'd1069555691,
		31'd1071646719, 31'd1072693760
	};

	typedef enum logic [4:0] {
		OP_NONE, OP_ACC, OP_CHECK, OP_NORM, OP_SQ_LD_SH, OP_SQ_STEP, OP_NB_LD,
		OP_MUL_D, OP_DIV_LD_COS, OP_DIV_STEP, OP_COS, OP_M0, OP_M1_SQ,
		OP_CORDIC_LD, OP_CORDIC_STEP, OP_M1_FIN, OP_M2_SQ, OP_M2_DIV_LD, OP_M2_G,
		OP_EXP_N, OP_EXP_J, OP_EXP_G, OP_M2_FIN, OP_LOAD
	} op_t;

	typedef enum logic [4:0] {
		ST_ACC, ST_CHECK, ST_NORM_A, ST_SQA_LD, ST_SQA, ST_NB_LD, ST_NORM_B,
		ST_SQB_LD, ST_SQB, ST_MUL_D, ST_DIV_LD, ST_DIV, ST_COS, ST_M0, ST_M1_SQ,
		ST_M1_SQRT, ST_CORDIC_LD, ST_CORDIC, ST_M1_FIN, ST_M2_SQ, ST_M2_SQRT,
		ST_M2_DIV_LD, ST_M2_DIV, ST_M2_G, ST_EXP_N, ST_EXP_J, ST_EXP_G, ST_M2_FIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       zero_norm;
		logic       norm_done;
		logic       sq_done;
		logic       div_done;
		logic       cordic_done;
		logic       exp_big;
		logic       exp_n_done;
		logic       exp_j_done;
		logic [1:0] mode;
	} dp_status_t;

	// Q30 product rounded half up.
	function automatic logic [30:0] mulq(input logic [30:0] a, input logic [30:0] b);
		logic [61:0] p;
		p = 62'(a) * 62'(b) + (62'd1 << 29);
		return p[60:30];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/vcs_dp.sv
// Datapath: accumulators, normalizer, square root, divider, CORDIC and exp sequencer.
`timescale 1ns / 1ps
`default_nettype none
module vcs_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_addr,
	input  wire logic [15:0]        cfg_wdata,
	input  wire logic [15:0]        elem_a,
	input  wire logic [15:0]        elem_b,
	input  wire vcs_pkg::op_t       op,
	output vcs_pkg::dp_status_t     status,
	output logic [17:0]             similarity,
	output logic                    zero_norm
);
	import vcs_pkg::*;

	logic [1:0]         mode_q;
	logic [15:0]        exp_scale_q;
	logic signed [41:0] dot_q;
	logic [40:0]        na_q, nb_q;

	logic [61:0] sh_q;
	logic [4:0]  hcnt_q;
	logic [5:0]  hsum_q;
	logic [62:0] sq_v_q, sq_res_q, sq_bit_q;
	logic [30:0] ra_q;
	logic [61:0] d_q;
	logic [62:0] dv_rem_q;
	logic [39:0] dv_num_q;
	logic [61:0] dv_den_q;
	logic [40:0] dv_q_q;
	logic [6:0]  dv_cnt_q;
	logic [30:0] c_q;
	logic        neg_q;
	logic signed [33:0] x_q, y_q;
	logic signed [26:0] z_q;
	logic [4:0]  it_q;
	logic [30:0] g_q, r_q;
	logic [3:0]  ecnt_q, ej_q;
	logic [9:0]  fb_q;
	logic [17:0] res_q;
	logic        zf_q;
	logic [17:0] sim_q;
	logic        zn_q;

	logic signed [31:0] prod_ab, prod_aa, prod_bb;
	logic signed [42:0] dot_sum;
	logic [41:0] na_sum, nb_sum;
	logic [42:0] dot_mag;
	logic [63:0] sq_sum;
	logic [62:0] rem2;
	logic        dv_ge;
	logic [41:0] cq1;
	logic [30:0] cos_c;
	logic [31:0] m0_sum;
	logic [61:0] cc;
	logic [32:0] v33;
	logic [15:0] sc;
	logic [39:0] ff;
	logic signed [33:0] xs, ys;
	logic signed [26:0] atan_v;
	logic [24:0] zc;
	logic [25:0] zr;
	logic [31:0] rr;
	logic [17:0] m2r;

	always_comb begin
		prod_ab = $signed(elem_a) * $signed(elem_b);
		prod_aa = $signed(elem_a) * $signed(elem_a);
		prod_bb = $signed(elem_b) * $signed(elem_b);
		dot_sum = {dot_q[41], dot_q} + {{11{prod_ab[31]}}, prod_ab};
		na_sum = {1'b0, na_q} + {11'b0, prod_aa[30:0]};
		nb_sum = {1'b0, nb_q} + {11'b0, prod_bb[30:0]};
		dot_mag = dot_q[41] ? 43'(-{dot_q[41], dot_q}) : {1'b0, dot_q};
		sq_sum = {1'b0, sq_res_q} + {1'b0, sq_bit_q};
		rem2 = {dv_rem_q[61:0], dv_num_q[39]};
		dv_ge = rem2 >= {1'b0, dv_den_q};
		cq1 = {1'b0, dv_q_q} + 42'd1;
		cos_c = (cq1[41:1] > 41'(ONE30)) ? ONE30 : cq1[31:1];
		m0_sum = {1'b0, c_q} + 32'd8192;
		cc = 62'(c_q) * 62'(c_q);
		v33 = neg_q ? (33'h0_8000_0000 + {1'b0, c_q, 1'b0})
		            : (33'h0_8000_0000 - {1'b0, c_q, 1'b0});
		sc = (exp_scale_q == 16'd0) ? 16'd1 : exp_scale_q;
		ff = 40'(dv_q_q[19:0]) * 40'(dv_q_q[19:0]);
		xs = x_q >>> it_q;
		ys = y_q >>> it_q;
		atan_v = $signed({3'b000, ATAN_TAB[it_q]});
		if (z_q < 0)
			zc = 25'd0;
		else if (z_q > $signed({2'b00, QUARTER24}))
			zc = QUARTER24;
		else
			zc = z_q[24:0];
		zr = {1'b0, zc} + 26'd128;
		rr = {1'b0, r_q} + 32'd8192;
		m2r = (rr[31:14] > SIM_ONE) ? SIM_ONE : rr[31:14];
	end

	always_comb begin
		status.zero_norm   = (na_q == 41'd0) || (nb_q == 41'd0);
		status.norm_done   = sh_q[61:60] != 2'b00;
		status.sq_done     = sq_bit_q == 63'd0;
		status.div_done    = dv_cnt_q == 7'd0;
		status.cordic_done = it_q == CORDIC_STEPS;
		status.exp_big     = |dv_q_q[40:34];
		status.exp_n_done  = ecnt_q == 4'd0;
		status.exp_j_done  = ej_q == EXP_J_END;
		status.mode        = mode_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_COS;
			exp_scale_q <= EXP_SCALE_RST;
			dot_q <= '0;
			na_q <= '0;
			nb_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_addr == REG_MODE)
					mode_q <= cfg_wdata[1:0];
				else
					exp_scale_q <= cfg_wdata;
			end
			if (op == OP_ACC) begin
				case (dot_sum[42:41])
					2'b01: dot_q <= 42'sh1FF_FFFF_FFFF;
					2'b10: dot_q <= 42'sh200_0000_0000;
					default: dot_q <= dot_sum[41:0];
				endcase
				na_q <= na_sum[41] ? 41'h1FF_FFFF_FFFF : na_sum[40:0];
				nb_q <= nb_sum[41] ? 41'h1FF_FFFF_FFFF : nb_sum[40:0];
			end else if (op == OP_LOAD) begin
				dot_q <= '0;
				na_q <= '0;
				nb_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_CHECK: begin
				sh_q <= {21'b0, na_q};
				hcnt_q <= '0;
				hsum_q <= '0;
				zf_q <= status.zero_norm;
				res_q <= '0;
			end
			OP_NORM: begin
				if (!status.norm_done) begin
					sh_q <= {sh_q[59:0], 2'b00};
					hcnt_q <= hcnt_q + 5'd1;
				end
			end
			OP_SQ_LD_SH: begin
				sq_v_q <= {1'b0, sh_q};
				sq_res_q <= '0;
				sq_bit_q <= SQ_BIT_INIT;
				hsum_q <= hsum_q + {1'b0, hcnt_q};
			end
			OP_SQ_STEP: begin
				if (!status.sq_done) begin
					if ({1'b0, sq_v_q} >= sq_sum) begin
						sq_v_q <= sq_v_q - sq_sum[62:0];
						sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
					end else begin
						sq_res_q <= sq_res_q >> 1;
					end
					sq_bit_q <= sq_bit_q >> 2;
				end
			end
			OP_NB_LD: begin
				ra_q <= sq_res_q[30:0];
				sh_q <= {21'b0, nb_q};
				hcnt_q <= '0;
			end
			OP_MUL_D: d_q <= 62'(ra_q) * 62'(sq_res_q[30:0]);
			OP_DIV_LD_COS: begin
				dv_rem_q <= {21'b0, dot_mag[41:0]};
				dv_num_q <= '0;
				dv_den_q <= d_q;
				dv_q_q <= '0;
				dv_cnt_q <= {1'b0, hsum_q} + 7'd31;
			end
			OP_DIV_STEP: begin
				if (!status.div_done) begin
					dv_rem_q <= dv_ge ? (rem2 - {1'b0, dv_den_q}) : rem2;
					if (!dv_q_q[40])
						dv_q_q <= {dv_q_q[39:0], dv_ge};
					dv_num_q <= {dv_num_q[38:0], 1'b0};
					dv_cnt_q <= dv_cnt_q - 7'd1;
				end
			end
			OP_COS: begin
				c_q <= cos_c;
				neg_q <= dot_q[41];
			end
			OP_M0: res_q <= neg_q ? -m0_sum[31:14] : m0_sum[31:14];
			OP_M1_SQ: begin
				sq_v_q <= {1'b0, ONE60 - cc};
				sq_res_q <= '0;
				sq_bit_q <= SQ_BIT_INIT;
			end
			OP_CORDIC_LD: begin
				x_q <= $signed({2'b00, sq_res_q[31:0]});
				y_q <= $signed({3'b000, c_q});
				z_q <= '0;
				it_q <= '0;
			end
			OP_CORDIC_STEP: begin
				if (!status.cordic_done) begin
					if (y_q > 0) begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + atan_v;
					end else begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - atan_v;
					end
					it_q <= it_q + 5'd1;
				end
			end
			OP_M1_FIN: res_q <= neg_q ? -zr[25:8] : zr[25:8];
			OP_M2_SQ: begin
				sq_v_q <= {v33, 30'b0};
				sq_res_q <= '0;
				sq_bit_q <= SQ_BIT_INIT;
			end
			OP_M2_DIV_LD: begin
				dv_rem_q <= '0;
				dv_num_q <= {sq_res_q[31:0], 8'b0};
				dv_den_q <= {46'b0, sc};
				dv_q_q <= '0;
				dv_cnt_q <= 7'd40;
			end
			OP_M2_G: begin
				g_q <= ONE30 - {11'b0, dv_q_q[19:0]} + {22'b0, ff[39:31]};
				r_q <= ONE30;
				ecnt_q <= dv_q_q[33:30];
				fb_q <= dv_q_q[29:20];
				ej_q <= 4'd1;
				res_q <= '0;
			end
			OP_EXP_N: begin
				if (!status.exp_n_done) begin
					r_q <= mulq(r_q, EXP_TAB[0]);
					ecnt_q <= ecnt_q - 4'd1;
				end
			end
			OP_EXP_J: begin
				if (!status.exp_j_done) begin
					if (fb_q[9])
						r_q <= mulq(r_q, EXP_TAB[ej_q]);
					fb_q <= {fb_q[8:0], 1'b0};
					ej_q <= ej_q + 4'd1;
				end
			end
			OP_EXP_G: r_q <= mulq(r_q, g_q);
			OP_M2_FIN: res_q <= m2r;
			OP_LOAD: begin
				sim_q <= res_q;
				zn_q <= zf_q;
			end
			default: ;
		endcase
	end

	assign similarity = sim_q;
	assign zero_norm = zn_q;

endmodule
`default_nettype wire

FILE: rtl/core/vcs_ctrl.sv
// Controller state machine that sequences the similarity datapath and the handshakes.
`timescale 1ns / 1ps
`default_nettype none
module vcs_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_last,
	input  wire logic                out_ready,
	input  wire vcs_pkg::dp_status_t status,
	output vcs_pkg::op_t             op,
	output logic                     in_ready,
	output logic                     out_valid
);
	import vcs_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   load_ok;

	assign load_ok = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_ACC:       if (in_valid && in_last) state_d = ST_CHECK;
			ST_CHECK:     state_d = status.zero_norm ? ST_OUT : ST_NORM_A;
			ST_NORM_A:    if (status.norm_done) state_d = ST_SQA_LD;
			ST_SQA_LD:    state_d = ST_SQA;
			ST_SQA:       if (status.sq_done) state_d = ST_NB_LD;
			ST_NB_LD:     state_d = ST_NORM_B;
			ST_NORM_B:    if (status.norm_done) state_d = ST_SQB_LD;
			ST_SQB_LD:    state_d = ST_SQB;
			ST_SQB:       if (status.sq_done) state_d = ST_MUL_D;
			ST_MUL_D:     state_d = ST_DIV_LD;
			ST_DIV_LD:    state_d = ST_DIV;
			ST_DIV:       if (status.div_done) state_d = ST_COS;
			ST_COS: begin
				case (status.mode)
					MODE_ANG: state_d = ST_M1_SQ;
					MODE_EXP: state_d = ST_M2_SQ;
					default:  state_d = ST_M0;
				endcase
			end
			ST_M0:        state_d = ST_OUT;
			ST_M1_SQ:     state_d = ST_M1_SQRT;
			ST_M1_SQRT:   if (status.sq_done) state_d = ST_CORDIC_LD;
			ST_CORDIC_LD: state_d = ST_CORDIC;
			ST_CORDIC:    if (status.cordic_done) state_d = ST_M1_FIN;
			ST_M1_FIN:    state_d = ST_OUT;
			ST_M2_SQ:     state_d = ST_M2_SQRT;
			ST_M2_SQRT:   if (status.sq_done) state_d = ST_M2_DIV_LD;
			ST_M2_DIV_LD: state_d = ST_M2_DIV;
			ST_M2_DIV:    if (status.div_done) state_d = ST_M2_G;
			ST_M2_G:      state_d = status.exp_big ? ST_OUT : ST_EXP_N;
			ST_EXP_N:     if (status.exp_n_done) state_d = ST_EXP_J;
			ST_EXP_J:     if (status.exp_j_done) state_d = ST_EXP_G;
			ST_EXP_G:     state_d = ST_M2_FIN;
			ST_M2_FIN:    state_d = ST_OUT;
			ST_OUT:       if (load_ok) state_d = ST_ACC;
			default:      state_d = ST_ACC;
		endcase
	end

	always_comb begin
		op = OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			ST_ACC: begin
				in_ready = 1'b1;
				if (in_valid)
					op = OP_ACC;
			end
			ST_CHECK:     op = OP_CHECK;
			ST_NORM_A:    op = OP_NORM;
			ST_SQA_LD:    op = OP_SQ_LD_SH;
			ST_SQA:       op = OP_SQ_STEP;
			ST_NB_LD:     op = OP_NB_LD;
			ST_NORM_B:    op = OP_NORM;
			ST_SQB_LD:    op = OP_SQ_LD_SH;
			ST_SQB:       op = OP_SQ_STEP;
			ST_MUL_D:     op = OP_MUL_D;
			ST_DIV_LD:    op = OP_DIV_LD_COS;
			ST_DIV:       op = OP_DIV_STEP;
			ST_COS:       op = OP_COS;
			ST_M0:        op = OP_M0;
			ST_M1_SQ:     op = OP_M1_SQ;
			ST_M1_SQRT:   op = OP_SQ_STEP;
			ST_CORDIC_LD: op = OP_CORDIC_LD;
			ST_CORDIC:    op = OP_CORDIC_STEP;
			ST_M1_FIN:    op = OP_M1_FIN;
			ST_M2_SQ:     op = OP_M2_SQ;
			ST_M2_SQRT:   op = OP_SQ_STEP;
			ST_M2_DIV_LD: op = OP_M2_DIV_LD;
			ST_M2_DIV:    op = OP_DIV_STEP;
			ST_M2_G:      op = OP_M2_G;
			ST_EXP_N:     op = OP_EXP_N;
			ST_EXP_J:     op = OP_EXP_J;
			ST_EXP_G:     op = OP_EXP_G;
			ST_M2_FIN:    op = OP_M2_FIN;
			ST_OUT:       if (load_ok) op = OP_LOAD;
			default:      op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (op == OP_LOAD)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

FILE: rtl/core/vector_cosine_similarity_unit.sv
// Top level of the streaming vector cosine similarity unit.
//
// The input stream carries one element pair per request: elem_a in tdata[15:0] and
// elem_b in tdata[31:16], both signed Q1.15, with tlast on the final pair.
// Pairs are accumulated at one per cycle by the three multiply-accumulate registers.
// After the last pair the input stalls while the shared square root (32 steps),
// the bit-serial divider (31 plus the two normalization shifts, each 10 to 30)
// and the mode unit run. Mode 1 adds a root and 24 CORDIC steps; mode 2 adds a
// root, a 40-step divide and the exp multiplies, whose number grows with the
// integer part of the distance term. The result leaves on the output stream:
// similarity (signed Q2.16) in tdata[17:0] and the zero norm flag in tuser. A
// finished result waits in the output register; if the receiver stalls, the next
// vector is still accumulated and computed, and only the hand-off of its result
// waits for that register to empty. Reset clears the accumulators and sets mode 0
// and exp_scale 256. The config port writes mode at index 0 and exp_scale at
// index 1; the user must write them only while the unit is idle, since the block
// itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module vector_cosine_similarity_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_addr,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // elem_a, elem_b
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // similarity, zero fill
	output logic             m_axis_tuser    // zero_norm
);
	import vcs_pkg::*;

	op_t        op;
	dp_status_t status;
	logic [17:0] similarity;
	logic        zero_norm;

	vcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_last   (s_axis_tlast),
		.out_ready (m_axis_tready),
		.status    (status),
		.op        (op),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid)
	);

	vcs_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.elem_a     (s_axis_tdata[15:0]),
		.elem_b     (s_axis_tdata[31:16]),
		.op         (op),
		.status     (status),
		.similarity (similarity),
		.zero_norm  (zero_norm)
	);

	assign m_axis_tdata = {6'b0, similarity};
	assign m_axis_tuser = zero_norm;

endmodule
`default_nettype wire

FILE: rtl/core/vcs_chk.sv
// Port-level checker for the cosine similarity unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "vector_cosine_similarity_unit_assert.svh"
module vcs_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        s_axis_tlast,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [23:0] m_axis_tdata,
	input wire logic        m_axis_tuser
);
	`VCSU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
	`VCSU_ASSERT_NOW(a_zero_norm_sim, m_axis_tvalid && m_axis_tuser, m_axis_tdata[17:0] == 18'd0, "zero norm result is not zero")
	`VCSU_ASSERT_NOW(a_sim_range, m_axis_tvalid, ($signed(m_axis_tdata[17:0]) >= -18'sd65536) && ($signed(m_axis_tdata[17:0]) <= 18'sd65536), "similarity out of range")
	`VCSU_ASSERT_NEXT(a_last_stalls, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "input accepted right after a last request")
endmodule

bind vector_cosine_similarity_unit vcs_chk u_vcs_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

FILE: verif/vector_cosine_similarity_unit_test.sv
// Self-checking stream testbench for the vector cosine similarity unit.
`timescale 1ns / 1ps
`default_nettype none
module vector_cosine_similarity_unit_test;
	import vcs_pkg::*;

	localparam logic [1:0] MODE_ALIAS = 2'd3;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int HOLD_CYCLES = 3000;
	localparam longint DOT_HI = 64'sh1FF_FFFF_FFFF;
	localparam longint DOT_LO = -64'sh200_0000_0000;
	localparam longint unsigned NORM_HI = 64'h1FF_FFFF_FFFF;
	localparam longint unsigned Q30_ONE = 64'd1 << 30;

	typedef struct {
		logic [17:0] sim;
		logic        zn;
	} sim_result_t;

	typedef struct {
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic               last;
		logic               typed;
		logic [17:0]        sim;
		logic               zn;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_addr;
	logic [15:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tuser;

	sim_result_t sim_expect_q[$];
	longint      dot_sum;
	longint unsigned norm_a_sum;
	longint unsigned norm_b_sum;
	logic [1:0]  cur_mode;
	logic [15:0] cur_scale;
	int          error_count;
	int          result_count;
	int          request_count;
	int          cycle_count;
	int          hold_left;
	int          stall_left;
	int          rx_roll;
	bit          hold_req;
	bit          burst;

	vector_cosine_similarity_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res;
		longint unsigned probe;
		res = 0;
		probe = 64'd1 << 62;
		while (probe > v)
			probe = probe >> 2;
		while (probe != 0) begin
			if (v >= res + probe) begin
				v = v - (res + probe);
				res = (res >> 1) + probe;
			end else begin
				res = res >> 1;
			end
			probe = probe >> 2;
		end
		return res;
	endfunction

	function automatic longint unsigned norm_sqrt(input longint unsigned n, output int shifts);
		shifts = 0;
		while (n < (64'd1 << 60)) begin
			n = n << 2;
			shifts++;
		end
		return int_sqrt(n);
	endfunction

	function automatic longint cosine_q30();
		longint unsigned ra, rb, d, mag, rem, q, c, qb;
		int ha, hb, k;
		ra = norm_sqrt(norm_a_sum, ha);
		rb = norm_sqrt(norm_b_sum, hb);
		d = ra * rb;
		mag = (dot_sum < 0) ? -dot_sum : dot_sum;
		rem = mag;
		q = 0;
		k = ha + hb + 31;
		for (int i = 0; i < k; i++) begin
			qb = 0;
			rem = rem << 1;
			if (rem >= d) begin
				rem = rem - d;
				qb = 1;
			end
			if (q < (64'd1 << 40))
				q = (q << 1) | qb;
		end
		c = (q + 1) >> 1;
		if (c > Q30_ONE)
			c = Q30_ONE;
		return (dot_sum < 0) ? -longint'(c) : longint'(c);
	endfunction

	function automatic longint angular_q16(input longint c);
		longint m, x, y, z, xs, ys, r;
		m = (c < 0) ? -c : c;
		x = int_sqrt((64'd1 << 60) - longint'(m * m));
		y = m;
		z = 0;
		for (int i = 0; i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_TAB[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_TAB[i];
			end
		end
		if (z < 0)
			z = 0;
		if (z > (64'sd1 << 24))
			z = 64'sd1 << 24;
		r = (z + 128) >>> 8;
		return (c < 0) ? -r : r;
	endfunction

	function automatic longint unsigned q30_product(input longint unsigned x, input longint unsigned y);
		return (x * y + (64'd1 << 29)) >> 30;
	endfunction

	function automatic longint exp_distance_q16(input longint c);
		longint unsigned v, u, sc, t, n, r, f, g;
		v = (64'd1 << 31) - longint'(2 * c);
		u = int_sqrt(v << 30);
		sc = (cur_scale == 0) ? 1 : cur_scale;
		t = (u << 8) / sc;
		n = t >> 30;
		if (n >= 16)
			return 0;
		r = Q30_ONE;
		for (int j = 0; j < n; j++)
			r = q30_product(r, EXP_TAB[0]);
		for (int j = 1; j <= 10; j++)
			if ((t >> (30 - j)) & 1)
				r = q30_product(r, EXP_TAB[j]);
		f = t & ((64'd1 << 20) - 1);
		g = Q30_ONE - f + ((f * f) >> 31);
		r = q30_product(r, g);
		r = (r + (64'd1 << 13)) >> 14;
		if (r > 65536)
			r = 65536;
		return longint'(r);
	endfunction

	// Accumulates one pair; returns 1 with the similarity when the pair closes a vector.
	function automatic bit accumulate_pair(input logic signed [15:0] a, input logic signed [15:0] b,
			input logic last, output sim_result_t res);
		longint sa, sb, c, m, sim;
		sa = a;
		sb = b;
		dot_sum = dot_sum + sa * sb;
		if (dot_sum > DOT_HI)
			dot_sum = DOT_HI;
		if (dot_sum < DOT_LO)
			dot_sum = DOT_LO;
		norm_a_sum = norm_a_sum + longint'(sa * sa);
		if (norm_a_sum > NORM_HI)
			norm_a_sum = NORM_HI;
		norm_b_sum = norm_b_sum + longint'(sb * sb);
		if (norm_b_sum > NORM_HI)
			norm_b_sum = NORM_HI;
		res.sim = '0;
		res.zn = 1'b0;
		if (!last)
			return 0;
		if (norm_a_sum == 0 || norm_b_sum == 0) begin
			res.zn = 1'b1;
		end else begin
			c = cosine_q30();
			if (cur_mode == MODE_ANG) begin
				sim = angular_q16(c);
			end else if (cur_mode == MODE_EXP) begin
				sim = exp_distance_q16(c);
			end else begin
				m = (c < 0) ? -c : c;
				m = (m + 8192) >>> 14;
				sim = (c < 0) ? -m : m;
			end
			res.sim = sim[17:0];
		end
		dot_sum = 0;
		norm_a_sum = 0;
		norm_b_sum = 0;
		return 1;
	endfunction

	task automatic write_reg(input logic addr, input logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (addr == REG_MODE)
			cur_mode = value[1:0];
		else
			cur_scale = value;
	endtask

	task automatic input_gap();
		int r, n;
		r = $urandom_range(0, 99);
		if (burst || r < 60)
			return;
		n = (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 60);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic send_pair(input logic signed [15:0] a, input logic signed [15:0] b,
			input logic last, input bit typed, input sim_result_t typed_res);
		sim_result_t res;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {b, a};
		s_axis_tlast <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		request_count++;
		if (accumulate_pair(a, b, last, res))
			sim_expect_q.push_back(typed ? typed_res : res);
		input_gap();
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sim_expect_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_elem(input int style);
		int r;
		r = $urandom_range(0, 5);
		if (style == 1) begin
			case (r)
				0: return 16'sh8000;
				1: return 16'sh7FFF;
				2: return 16'sh0000;
				3: return -16'sd1;
				default: return 16'sd1;
			endcase
		end
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic random_vectors(input int count);
		sim_result_t none;
		logic signed [15:0] a, b;
		int len, style, r;
		none.sim = '0;
		none.zn = 1'b0;
		for (int v = 0; v < count; v++) begin
			r = $urandom_range(0, 99);
			len = (r < 70) ? $urandom_range(1, 6) : (r < 96) ? $urandom_range(7, 40) :
				$urandom_range(41, 150);
			style = $urandom_range(0, 5);
			if ($urandom_range(0, 9) == 0)
				burst = !burst;
			for (int i = 0; i < len; i++) begin
				a = pick_elem(style);
				case (style)
					2: b = a;
					3: b = -a;
					4: b = a + $signed(16'($urandom_range(0, 255)) - 16'sd128);
					default: b = pick_elem(style);
				endcase
				if (style == 5 && $urandom_range(0, 1))
					a = 16'sd0;
				send_pair(a, b, i == len - 1, 1'b0, none);
			end
		end
	endtask

	stim_row_t directed_rows[19] = '{
		'{16'sd0, 16'sd0, 1'b1, 1'b1, 18'd0, 1'b1},
		'{16'sh7FFF, 16'sd0, 1'b1, 1'b1, 18'd0, 1'b1},
		'{16'sd0, 16'sh8000, 1'b1, 1'b1, 18'd0, 1'b1},
		'{16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1, 18'd65536, 1'b0},
		'{16'sh8000, 16'sh8000, 1'b1, 1'b1, 18'd65536, 1'b0},
		'{16'sh7FFF, -16'sh7FFF, 1'b1, 1'b1, -18'sd65536, 1'b0},
		'{16'sh8000, 16'sh7FFF, 1'b1, 1'b1, -18'sd65536, 1'b0},
		'{16'sd1, 16'sd0, 1'b0, 1'b0, 18'd0, 1'b0},
		'{16'sd0, 16'sd1, 1'b1, 1'b1, 18'd0, 1'b0},
		'{16'sh5555, 16'shAAAA, 1'b0, 1'b0, 18'd0, 1'b0},
		'{16'shAAAA, 16'sh5555, 1'b1, 1'b0, 18'd0, 1'b0},
		'{16'sd12345, -16'sd222, 1'b0, 1'b0, 18'd0, 1'b0},
		'{16'sh8000, 16'sh7FFF, 1'b0, 1'b0, 18'd0, 1'b0},
		'{16'sd1, -16'sd1, 1'b1, 1'b0, 18'd0, 1'b0},
		'{16'sd1, 16'sd1, 1'b0, 1'b0, 18'd0, 1'b0},
		'{16'sd1, 16'sd2, 1'b1, 1'b0, 18'd0, 1'b0},
		'{-16'sd1, 16'sd0, 1'b0, 1'b0, 18'd0, 1'b0},
		'{16'sd0, 16'sd0, 1'b1, 1'b1, 18'd0, 1'b1},
		'{16'sd300, 16'sd299, 1'b1, 1'b0, 18'd0, 1'b0}
	};

	initial begin
		sim_result_t typed_res;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		hold_req = 1'b0;
		burst = 1'b0;
		error_count = 0;
		result_count = 0;
		request_count = 0;
		dot_sum = 0;
		norm_a_sum = 0;
		norm_b_sum = 0;
		cur_mode = MODE_COS;
		cur_scale = EXP_SCALE_RST;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			typed_res.sim = directed_rows[i].sim;
			typed_res.zn = directed_rows[i].zn;
			send_pair(directed_rows[i].a, directed_rows[i].b, directed_rows[i].last,
				directed_rows[i].typed, typed_res);
		end
		drain_results();

		// The receiver holds off while random vectors keep coming, so the input must stall.
		hold_req = 1'b1;
		random_vectors(25);
		drain_results();

		write_reg(REG_MODE, 16'(MODE_ANG));
		random_vectors(15);
		drain_results();
		write_reg(REG_MODE, 16'(MODE_EXP));
		random_vectors(15);
		drain_results();
		write_reg(REG_EXP_SCALE, 16'd1);
		random_vectors(8);
		drain_results();
		write_reg(REG_EXP_SCALE, 16'hFFFF);
		random_vectors(8);
		drain_results();
		write_reg(REG_EXP_SCALE, 16'd0);
		random_vectors(8);
		drain_results();
		write_reg(REG_EXP_SCALE, 16'(32 + $urandom_range(0, 600)));
		random_vectors(8);
		drain_results();
		write_reg(REG_MODE, 16'(MODE_ALIAS));
		random_vectors(8);
		drain_results();
		write_reg(REG_MODE, 16'(MODE_COS));
		random_vectors(8);
		drain_results();
		repeat (600) @(posedge clk);

		$display("Ran %0d requests and checked %0d similarity results", request_count,
			result_count);
		$display("across cosine, angular, exponential and aliased modes with stalls.");
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			rx_roll = $urandom_range(0, 99);
			if (rx_roll < 4)
				stall_left = $urandom_range(10, 60);
			m_axis_tready <= burst || rx_roll >= 25;
		end
	end

	initial begin
		m_axis_tready = 1'b0;
		hold_left = 0;
		stall_left = 0;
	end

	always @(posedge clk) begin
		sim_result_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			result_count++;
			if (sim_expect_q.size() == 0) begin
				$error("similarity result arrived with none expected");
				error_count++;
			end else begin
				want = sim_expect_q.pop_front();
				if (m_axis_tdata[17:0] !== want.sim) begin
					$error("similarity: expected %0d, got %0d", $signed(want.sim),
						$signed(m_axis_tdata[17:0]));
					error_count++;
				end
				if (m_axis_tuser !== want.zn) begin
					$error("zero_norm: expected %0d, got %0d", want.zn, m_axis_tuser);
					error_count++;
				end
			end
		end
	end

	initial cycle_count = 0;

endmodule
`default_nettype wire

FILE: sim.f
+incdir+rtl/core
rtl/core/vcs_pkg.sv
rtl/core/vcs_dp.sv
rtl/core/vcs_ctrl.sv
rtl/core/vector_cosine_similarity_unit.sv
rtl/core/vcs_chk.sv
verif/vector_cosine_similarity_unit_test.sv
